// File: rtl/mmg8_pkg.sv
`default_nettype none

package mmg8_pkg;

   // Fixed-point format of the samples
   localparam int FRAC_BITS  = 16;
   localparam int SAMPLE_W   = 32;
   localparam int GRAY_W     = 8;
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int NUM_W      = SAMPLE_W + GRAY_W;
   localparam int DIV_STEPS  = GRAY_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam logic [GRAY_W-1:0] GRAY_MAX = {GRAY_W{1'b1}};
   localparam logic [DIFF_W-1:0] UNIT_SPAN = DIFF_W'(1) << FRAC_BITS;

   // Sample kind carried in tuser
   localparam logic KIND_SCAN    = 1'b0;
   localparam logic KIND_CONVERT = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_RND  = 5'b10000
   } state_type;

   typedef struct packed {
      logic scan_upd;   // fold sample into range
      logic conv_load;  // latch sample for conversion
      logic prep;       // offset, span, saturation flags
      logic mul;        // offset * 255, seed remainder
      logic div_step;   // one restoring quotient bit
      logic out_load;   // round and load output register
   } cmd_type;

   typedef struct packed {
      logic out_free;   // output register empty or being drained
   } status_type;

endpackage

`default_nettype wire

// File: rtl/mmg8_ctrl.sv
`default_nettype none

module mmg8_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   input  wire                  req_tuser,
   output logic                 req_tready,
   input  mmg8_pkg::status_type status,
   output mmg8_pkg::cmd_type    cmd
);
   import mmg8_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.scan_upd  = accept & (req_tuser == KIND_SCAN);
            cmd.conv_load = accept & (req_tuser == KIND_CONVERT);
            if (accept && (req_tuser == KIND_CONVERT)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/mmg8_dp.sv
`default_nettype none

module mmg8_dp (
   input  wire                              clock,
   input  wire                              reset,
   input  mmg8_pkg::cmd_type                cmd,
   output mmg8_pkg::status_type             status,
   input  wire [mmg8_pkg::SAMPLE_W-1:0]     req_tdata,
   input  wire                              req_tlast,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [mmg8_pkg::GRAY_W-1:0]      rsp_tdata,
   output logic                             rsp_tlast
);
   import mmg8_pkg::*;

   logic signed [SAMPLE_W-1:0] min_ff, max_ff, x_ff, samp;
   logic                       new_frame_ff, last_ff;
   logic signed [DIFF_W-1:0]   off_c, diff_c, off_ff;
   logic [DIFF_W-1:0]          span_c, span_ff;
   logic                       lo_c, hi_c, lo_ff, hi_ff;
   logic [NUM_W-1:0]           off_w, num_c;
   logic [DIFF_W-1:0]          r_ff;
   logic [GRAY_W-1:0]          nlow_ff, q_ff;
   logic [DIFF_W:0]            trial, twor, span_x;
   logic                       qbit, round_up;
   logic [GRAY_W:0]            q_rnd;
   logic [GRAY_W-1:0]          gray_c;
   logic                       valid_ff;
   logic [GRAY_W-1:0]          gray_ff;
   logic                       tlast_ff;

   assign samp = $signed(req_tdata);

   // range tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= '0;
         max_ff       <= '0;
         new_frame_ff <= 1'b1;
      end else if (cmd.scan_upd) begin
         if (new_frame_ff) begin
            min_ff       <= samp;
            max_ff       <= samp;
            new_frame_ff <= 1'b0;
         end else begin
            if (samp < min_ff) min_ff <= samp;
            if (samp > max_ff) max_ff <= samp;
         end
      end else if (cmd.conv_load && req_tlast) begin
         new_frame_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.conv_load) begin
         x_ff    <= samp;
         last_ff <= req_tlast;
      end
   end

   // offset and span
   assign off_c  = DIFF_W'(x_ff) - DIFF_W'(min_ff);
   assign diff_c = DIFF_W'(max_ff) - DIFF_W'(min_ff);
   assign span_c = (diff_c > 0) ? $unsigned(diff_c) : UNIT_SPAN;
   assign lo_c   = (off_c <= 0);
   assign hi_c   = !lo_c && ($unsigned(off_c) >= span_c);

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         off_ff  <= off_c;
         span_ff <= span_c;
         lo_ff   <= lo_c;
         hi_ff   <= hi_c;
      end
   end

   // off * 255 as (off << 8) - off; only meaningful when off < span
   assign off_w = NUM_W'($unsigned(off_ff[SAMPLE_W-1:0]));
   assign num_c = (off_w << GRAY_W) - off_w;

   // restoring divider, one quotient bit per step
   assign trial = {r_ff, nlow_ff[GRAY_W-1]};
   assign span_x = {1'b0, span_ff};
   assign qbit  = (trial >= span_x);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         r_ff    <= DIFF_W'(num_c[NUM_W-1:GRAY_W]);
         nlow_ff <= num_c[GRAY_W-1:0];
         q_ff    <= '0;
      end else if (cmd.div_step) begin
         r_ff    <= qbit ? DIFF_W'(trial - span_x) : trial[DIFF_W-1:0];
         nlow_ff <= {nlow_ff[GRAY_W-2:0], 1'b0};
         q_ff    <= {q_ff[GRAY_W-2:0], qbit};
      end
   end

   // round half to even, then clamp
   assign twor     = {r_ff, 1'b0};
   assign round_up = (twor > span_x) || ((twor == span_x) && q_ff[0]);
   assign q_rnd    = {1'b0, q_ff} + (GRAY_W+1)'(round_up);

   always_comb begin
      if (lo_ff) begin
         gray_c = '0;
      end else if (hi_ff || q_rnd[GRAY_W]) begin
         gray_c = GRAY_MAX;
      end else begin
         gray_c = q_rnd[GRAY_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         gray_ff  <= gray_c;
         tlast_ff <= last_ff;
      end
   end

   assign status.out_free = !valid_ff || rsp_tready;
   assign rsp_tvalid      = valid_ff;
   assign rsp_tdata       = gray_ff;
   assign rsp_tlast       = tlast_ff;

endmodule

`default_nettype wire

// File: rtl/minmax_normalize_to_gray8.sv
// Scan sample: folded into the range, input ready again at the next edge, no result.
// Convert sample: prep, multiply, 8-step restoring divider, then rounding,
//   which waits for a free output register; input stalled until then.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active high): range min = max = 0, next scan sample
//   opens a new range, no result pending.
`default_nettype none

module minmax_normalize_to_gray8 (
   input  wire                          clock,
   input  wire                          reset,
   // input channel
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire [mmg8_pkg::SAMPLE_W-1:0] req_tdata,   // [31:0] sample (signed Q15.16)
   input  wire                          req_tuser,   // [0] kind: 0 scan, 1 convert
   input  wire                          req_tlast,   // last sample of the pass
   // result channel
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [mmg8_pkg::GRAY_W-1:0]  rsp_tdata,   // [7:0] gray
   output logic                         rsp_tlast    // final_res
);
   import mmg8_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: accept, prep, multiply, divide, round/transfer
   mmg8_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // range registers, divider and output register
   mmg8_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // a scan transfer never produces a result
   a_scan_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == KIND_SCAN) && !rsp_tvalid)
      |=> !rsp_tvalid)
      else $error("scan transfer produced a result");

   // a convert transfer keeps the input stalled while it is worked on
   a_conv_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == KIND_CONVERT)) |=> !req_tready)
      else $error("input accepted during conversion");

   // a result is only loaded from the rounding step, never from idle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a conversion");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mmg8_pkg::*;

   // Idle draw range for both sides, cycles per item
   localparam int GAP_MAX      = 18;
   // Cycles without any transfer before the run is abandoned
   localparam int STALL_LIMIT  = 4000;
   // Settling time after the last result (divider latency plus margin)
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 2000;
   // Only the first few mismatches are printed, all are counted
   localparam int PRINT_LIMIT  = 50;

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
      logic              final_res;
   } gray_result_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata;    // [31:0] sample (signed Q15.16)
   logic                req_tuser;    // [0] kind: scan or convert
   logic                req_tlast;    // last sample of the pass
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [GRAY_W-1:0]   rsp_tdata;    // [7:0] gray
   logic                rsp_tlast;    // final_res

   // Predicted range, mirrors the block's running min/max
   logic signed [SAMPLE_W-1:0] range_lo;
   logic signed [SAMPLE_W-1:0] range_hi;
   logic                       range_open;   // next scan sample restarts the range

   gray_result_type gray_due[$];             // gray levels still to arrive, oldest first
   int           mismatch_count;
   int           items_sent;
   bit           no_idle;                    // forces back-to-back transfers on both sides

   minmax_normalize_to_gray8 uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Exact gray level of a sample against the predicted range: offset*255/span,
   // rounded half to even, saturated at both ends. Zero span counts as 1.0.
   function automatic logic [GRAY_W-1:0] predict_gray(input logic signed [SAMPLE_W-1:0] x);
      longint span;
      longint offset;
      longint num;
      longint quo;
      longint rem;
      span = longint'(range_hi) - longint'(range_lo);
      if (span <= 0) span = longint'(UNIT_SPAN);
      offset = longint'(x) - longint'(range_lo);
      if (offset <= 0) return '0;
      if (offset >= span) return GRAY_MAX;
      num = offset * longint'(GRAY_MAX);
      quo = num / span;
      rem = num % span;
      if ((2 * rem > span) || ((2 * rem == span) && (quo % 2 == 1))) quo++;
      if (quo > longint'(GRAY_MAX)) quo = longint'(GRAY_MAX);
      return GRAY_W'(quo);
   endfunction

   // Applies one accepted sample to the predicted state; converts queue a gray level
   task automatic fold_sample(input logic kind, input logic signed [SAMPLE_W-1:0] x,
                              input logic last);
      if (kind == KIND_SCAN) begin
         if (range_open) begin
            range_lo   = x;
            range_hi   = x;
            range_open = 1'b0;
         end else begin
            if (x < range_lo) range_lo = x;
            if (x > range_hi) range_hi = x;
         end
      end else begin
         gray_due.push_back('{gray: predict_gray(x), final_res: last});
         // end of a convert pass: next scan opens a fresh range
         if (last) range_open = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   function automatic int draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, GAP_MAX);
   endfunction

   // One transfer on the input channel. Drive at the falling edge, sample at
   // the rising edge; tvalid only drops when an idle gap is drawn.
   task automatic send_sample(input logic kind, input logic [SAMPLE_W-1:0] x,
                              input logic last);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      req_tuser  <= kind;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      fold_sample(kind, x, last);
      items_sent++;
   endtask

   // Sample near the frame's base, spread chosen per frame
   function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] base,
                                                       input logic [SAMPLE_W-1:0] spread);
      if (spread == 0) return base;
      return base + ($urandom % spread);
   endfunction

   // Convert samples: mostly inside the scanned range, some on the bounds,
   // some just beyond a bound or anywhere at random
   function automatic logic [SAMPLE_W-1:0] pick_convert(input logic [SAMPLE_W-1:0] base,
                                                        input logic [SAMPLE_W-1:0] spread);
      case ($urandom_range(0, 9))
         0:       return range_lo;
         1:       return range_hi;
         2:       return $urandom;
         3:       return range_lo - $urandom_range(1, 300);
         4:       return range_hi + $urandom_range(1, 300);
         default: return pick_sample(base, spread);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      gray_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (gray_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result gray=%0d last=%0b",
                                      rsp_tdata, rsp_tlast));
         end else begin
            want = gray_due.pop_front();
            if (rsp_tdata !== want.gray)
               report_mismatch($sformatf("gray %0d, expected %0d", rsp_tdata, want.gray));
            if (rsp_tlast !== want.final_res)
               report_mismatch($sformatf("last %0b, expected %0b",
                                         rsp_tlast, want.final_res));
         end
      end
   end

   // Result side back-pressure: a random stall before each transfer
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog: any transfer on either channel restarts the count
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Converts straight after reset use the reset range 0..0, i.e. span 1.0
   task automatic test_convert_before_scan();
      send_sample(KIND_CONVERT, 32'h0000_0000, 1'b0);
      send_sample(KIND_CONVERT, 32'h0000_8000, 1'b0);   // 127.5, tie goes to 128
      send_sample(KIND_CONVERT, 32'h0000_0080, 1'b0);
      send_sample(KIND_CONVERT, 32'h0001_0000, 1'b0);   // exactly the span
      send_sample(KIND_CONVERT, 32'h8000_0000, 1'b0);   // far below
      send_sample(KIND_CONVERT, 32'h7FFF_FFFF, 1'b1);   // far above, closes the pass
   endtask

   // Single scan sample: min equals max, span falls back to 1.0
   task automatic test_zero_span();
      send_sample(KIND_SCAN,    32'h0003_0000, 1'b1);
      send_sample(KIND_CONVERT, 32'h0003_0000, 1'b0);
      send_sample(KIND_CONVERT, 32'h0003_8000, 1'b0);
      send_sample(KIND_CONVERT, 32'h0002_FFFF, 1'b1);
   endtask

   // Span of 510 LSBs puts odd offsets exactly on a half
   task automatic test_tie_rounding();
      send_sample(KIND_SCAN,    32'd0,   1'b0);
      send_sample(KIND_SCAN,    32'd510, 1'b1);
      send_sample(KIND_CONVERT, 32'd1,   1'b0);   // 0.5 -> 0
      send_sample(KIND_CONVERT, 32'd3,   1'b0);   // 1.5 -> 2
      send_sample(KIND_CONVERT, 32'd255, 1'b0);   // 127.5 -> 128
      send_sample(KIND_CONVERT, 32'd509, 1'b1);
   endtask

   // Full signed range; a last flag on a scan sample must not reopen the range
   task automatic test_full_range();
      send_sample(KIND_SCAN,    32'h7FFF_FFFF, 1'b0);
      send_sample(KIND_SCAN,    32'h8000_0000, 1'b0);
      send_sample(KIND_SCAN,    32'h0000_0000, 1'b1);
      send_sample(KIND_SCAN,    32'h1234_5678, 1'b0);
      send_sample(KIND_CONVERT, 32'h8000_0000, 1'b0);
      send_sample(KIND_CONVERT, 32'h7FFF_FFFF, 1'b0);
      send_sample(KIND_CONVERT, 32'h0000_0000, 1'b0);
      send_sample(KIND_CONVERT, 32'hFFFF_FFFF, 1'b1);
   endtask

   // Mostly well-formed frames (scan pass, then convert pass) with random
   // content, mixed with runs of noise: random kind and last flags
   task automatic test_random_frames();
      int              stop_at;
      int              n_scan;
      int              n_conv;
      logic [SAMPLE_W-1:0] base;
      logic [SAMPLE_W-1:0] spread;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         no_idle = ($urandom_range(0, 4) == 0);
         base    = $urandom;
         case ($urandom_range(0, 3))
            0:       spread = '0;
            1:       spread = $urandom_range(1, 1000);
            2:       spread = $urandom_range(1, 1 << 20);
            default: spread = $urandom;
         endcase
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 8))
               send_sample(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
         end else begin
            n_scan = $urandom_range(1, 12);
            for (int i = 0; i < n_scan; i++)
               send_sample(KIND_SCAN, pick_sample(base, spread), i == n_scan - 1);
            n_conv = $urandom_range(1, 12);
            for (int i = 0; i < n_conv; i++)
               send_sample(KIND_CONVERT, pick_convert(base, spread), i == n_conv - 1);
         end
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = KIND_SCAN;
      req_tlast      = 1'b0;
      range_lo       = '0;
      range_hi       = '0;
      range_open     = 1'b1;
      mismatch_count = 0;
      items_sent     = 0;
      no_idle        = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_convert_before_scan();
      test_zero_span();
      test_tie_rounding();
      test_full_range();
      test_random_frames();

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (gray_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: files.f
rtl/mmg8_pkg.sv
rtl/mmg8_ctrl.sv
rtl/mmg8_dp.sv
rtl/minmax_normalize_to_gray8.sv
bench/tb_top.sv
